### rtl/core/sbus_frame_channel_decoder_unit_defines.svh
// ---------------------------------------------------------------------------
// SBUS frame channel decoder: assertion macros
// Concurrent assertion wrappers, empty in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef SBUS_FRAME_CHANNEL_DECODER_UNIT_DEFINES_SVH
`define SBUS_FRAME_CHANNEL_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SBFD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbfd assertion failed");
// next-cycle implication
`define SBFD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbfd assertion failed");
`else
`define SBFD_ASSERT_IMP(label, clk, rst, ante, cons)
`define SBFD_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/core/sbfd_pkg.sv
// ---------------------------------------------------------------------------
// SBUS frame channel decoder package
// Widths, frame layout constants, item codes and the channel value mapping.
// ---------------------------------------------------------------------------
`default_nettype none

package sbfd_pkg;

  localparam int FRAME_BYTES  = 25;
  localparam int STORE_DEPTH  = FRAME_BYTES - 2;      // frame bytes 1..23
  localparam int MEM_DEPTH    = 2 * STORE_DEPTH;      // two frame banks
  localparam int MEM_AW       = $clog2(MEM_DEPTH);
  localparam int ST_AW        = $clog2(STORE_DEPTH);
  localparam int POS_W        = $clog2(FRAME_BYTES + 1);

  localparam int BYTE_W       = 8;
  localparam int CH_W         = 11;
  localparam int MAP_W        = 12;
  localparam int IDX_W        = 5;
  localparam int ACC_W        = CH_W - 1 + BYTE_W;    // worst-case bits held
  localparam int CNT_W        = $clog2(ACC_W + 1);

  localparam int CFG_W        = CH_W;
  localparam int CFG_IDX_W    = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STICK_CENTER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KNOB_OFFSET  = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] STICK_CENTER_RST = CFG_W'(1024);
  localparam logic [CFG_W-1:0] KNOB_OFFSET_RST  = CFG_W'(240);

  // byte positions within a frame
  localparam logic [POS_W-1:0] POS_FIRST = POS_W'(1);
  localparam logic [POS_W-1:0] POS_FLAGS = POS_W'(STORE_DEPTH);
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] POS_IDLE  = POS_W'(FRAME_BYTES);

  // 16 channels x 11 bits fill exactly 22 bytes
  localparam int NUM_CHANNELS = 16;
  localparam logic [ST_AW-1:0] CH_BYTES = ST_AW'(NUM_CHANNELS * CH_W / BYTE_W);

  // flag byte bit positions
  localparam int FLAG_DIG0_BIT = 7;
  localparam int FLAG_DIG1_BIT = 6;
  localparam int FLAG_FS_BIT   = 3;
  localparam int FLAG_LOST_BIT = 2;

  // item codes
  localparam logic [IDX_W-1:0] ITEM_STICK_FIRST = IDX_W'(0);
  localparam logic [IDX_W-1:0] ITEM_STICK_LAST  = IDX_W'(3);
  localparam logic [IDX_W-1:0] ITEM_SW_A        = IDX_W'(4);
  localparam logic [IDX_W-1:0] ITEM_SW_B        = IDX_W'(5);
  localparam logic [IDX_W-1:0] ITEM_SW_C        = IDX_W'(6);
  localparam logic [IDX_W-1:0] ITEM_SW_D        = IDX_W'(7);
  localparam logic [IDX_W-1:0] ITEM_KNOB_FIRST  = IDX_W'(8);
  localparam logic [IDX_W-1:0] ITEM_KNOB_LAST   = IDX_W'(9);
  localparam logic [IDX_W-1:0] ITEM_HOLD_END    = IDX_W'(10);
  localparam logic [IDX_W-1:0] ITEM_CH_END      = IDX_W'(NUM_CHANNELS);
  localparam logic [IDX_W-1:0] ITEM_DIG0        = IDX_W'(16);
  localparam logic [IDX_W-1:0] ITEM_LAST        = IDX_W'(17);

  localparam int DIV_SW3 = 904;
  localparam int DIV_SW6 = 603;

  function automatic logic signed [MAP_W-1:0] map_value(
    input logic [IDX_W-1:0] k,
    input logic [CH_W-1:0]  raw,
    input logic [CFG_W-1:0] center,
    input logic [CFG_W-1:0] knob,
    input logic             hold
  );
    logic [MAP_W-1:0] v;
    logic [1:0]       q;
    q = 2'd0;
    case (k) inside
      [ITEM_STICK_FIRST:ITEM_STICK_LAST]: begin
        v = {1'b0, raw} - {1'b0, center};
      end
      ITEM_SW_A, ITEM_SW_B, ITEM_SW_D: begin
        if (raw >= CH_W'(2 * DIV_SW3)) q = 2'd2;
        else if (raw >= CH_W'(DIV_SW3)) q = 2'd1;
        v = MAP_W'(q);
      end
      ITEM_SW_C: begin
        if (raw >= CH_W'(3 * DIV_SW6)) q = 2'd3;
        else if (raw >= CH_W'(2 * DIV_SW6)) q = 2'd2;
        else if (raw >= CH_W'(DIV_SW6)) q = 2'd1;
        v = MAP_W'(q);
      end
      [ITEM_KNOB_FIRST:ITEM_KNOB_LAST]: begin
        v = {1'b0, raw} - {1'b0, knob};
      end
      default: begin
        v = {1'b0, raw};
      end
    endcase
    if (hold && (k < ITEM_HOLD_END)) v = '0;
    return $signed(v);
  endfunction

endpackage

`default_nettype wire

### rtl/core/sbfd_ifs.sv
// ---------------------------------------------------------------------------
// SBUS frame channel decoder channels
// Valid/ready channels for frame bytes in and decoded channel results out.
// ---------------------------------------------------------------------------
`default_nettype none

interface sbfd_rx_if;
  import sbfd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              frame_start;
  modport source (output valid, rx_byte, frame_start, input ready);
  modport sink   (input valid, rx_byte, frame_start, output ready);
endinterface

interface sbfd_res_if;
  import sbfd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        item_index;
  logic [CH_W-1:0]         raw_value;
  logic signed [MAP_W-1:0] mapped_value;
  logic                    failsafe;
  logic                    frame_lost;
  logic                    last_item;
  modport source (output valid, item_index, raw_value, mapped_value, failsafe,
                  frame_lost, last_item, input ready);
  modport sink   (input valid, item_index, raw_value, mapped_value, failsafe,
                  frame_lost, last_item, output ready);
endinterface

`default_nettype wire

### rtl/core/sbus_frame_channel_decoder_unit.sv
// Drain start: the first result is registered once two stored bytes are absorbed.
// Throughput: one byte per cycle in; input stalls only when a frame ends while
//   the previous burst drains. A frame's 18 results come from 22 packed bytes,
//   at most one store read and one result per cycle, held by output back-pressure.
// Reset: idle awaiting a start byte, registers to defaults; byte store not cleared.
// ---------------------------------------------------------------------------
// SBUS frame channel decoder
// Stores frame bytes in a two-bank RAM, unpacks 11-bit channels through a bit
// accumulator, maps stick, switch and knob channels and emits two digital flags.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sbus_frame_channel_decoder_unit_defines.svh"

module sbus_frame_channel_decoder_unit (
  input  logic                           clk,
  input  logic                           rst,
  sbfd_rx_if.sink                        rx,
  sbfd_res_if.source                     res,
  input  logic                           cfg_wr_en,
  input  logic [sbfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbfd_pkg::CFG_W-1:0]     cfg_data
);
  import sbfd_pkg::*;

  function automatic logic [MEM_AW-1:0] mem_addr(input logic bank,
                                                 input logic [ST_AW-1:0] idx);
    return bank ? MEM_AW'(idx) + MEM_AW'(STORE_DEPTH) : MEM_AW'(idx);
  endfunction

  // configuration
  logic [CFG_W-1:0] stick_center;
  logic [CFG_W-1:0] knob_offset;

  // frame capture
  logic [POS_W-1:0]  pos;
  logic              wbank;
  logic [BYTE_W-1:0] flags_w;

  // drain engine
  logic              busy;
  logic              dbank;
  logic [BYTE_W-1:0] flags_d;
  logic [ST_AW-1:0]  raddr;
  logic              rd_vld;
  logic [BYTE_W-1:0] rdata;
  logic [ACC_W-1:0]  acc;
  logic [CNT_W-1:0]  cnt;
  logic [IDX_W-1:0]  k;

  logic [BYTE_W-1:0] mem [MEM_DEPTH];

  // output register
  logic                    out_valid;
  logic [IDX_W-1:0]        out_index;
  logic [CH_W-1:0]         out_raw;
  logic signed [MAP_W-1:0] out_mapped;
  logic                    out_fs;
  logic                    out_lost;
  logic                    out_last;

  logic             rx_go;
  logic             wr_en;
  logic             frame_done;
  logic [ST_AW-1:0] wr_idx;
  logic             out_free;
  logic             chan_phase;
  logic             emit;
  logic             absorb;
  logic             rd_en;
  logic [CH_W-1:0]  raw_sel;
  logic             fs;
  logic             lost;

  // a frame cannot complete into the bank still draining
  assign rx.ready   = !(busy && (pos == POS_LAST));
  assign rx_go      = rx.valid && rx.ready;
  assign wr_en      = rx_go && !rx.frame_start && (pos >= POS_FIRST) && (pos <= POS_FLAGS);
  assign frame_done = rx_go && !rx.frame_start && (pos == POS_LAST);
  assign wr_idx     = ST_AW'(pos - POS_FIRST);

  assign out_free   = !out_valid || res.ready;
  assign chan_phase = k < ITEM_CH_END;
  assign emit       = busy && out_free && (!chan_phase || (cnt >= CNT_W'(CH_W)));
  assign absorb     = busy && chan_phase && (cnt < CNT_W'(CH_W)) && rd_vld;
  assign rd_en      = busy && (raddr < CH_BYTES) && (!rd_vld || absorb);

  assign fs   = flags_d[FLAG_FS_BIT];
  assign lost = flags_d[FLAG_LOST_BIT];

  always_comb begin
    if (chan_phase) begin
      raw_sel = acc[CH_W-1:0];
    end else if (k == ITEM_DIG0) begin
      raw_sel = CH_W'(flags_d[FLAG_DIG0_BIT]);
    end else begin
      raw_sel = CH_W'(flags_d[FLAG_DIG1_BIT]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stick_center <= STICK_CENTER_RST;
      knob_offset  <= KNOB_OFFSET_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_STICK_CENTER: stick_center <= cfg_data;
        REG_KNOB_OFFSET:  knob_offset  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_IDLE;
    end else if (rx_go) begin
      if (rx.frame_start) begin
        pos <= POS_FIRST;
      end else if (pos < POS_IDLE) begin
        pos <= pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (pos == POS_FLAGS)) begin
      flags_w <= rx.rx_byte;
    end
  end

  // frame RAM: capture bank written, drain bank read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[mem_addr(wbank, wr_idx)] <= rx.rx_byte;
    end
    if (rd_en) begin
      rdata <= mem[mem_addr(dbank, raddr)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      wbank  <= 1'b0;
      dbank  <= 1'b0;
      rd_vld <= 1'b0;
      raddr  <= '0;
      cnt    <= '0;
      k      <= '0;
    end else if (frame_done) begin
      busy    <= 1'b1;
      dbank   <= wbank;
      wbank   <= !wbank;
      flags_d <= flags_w;
      rd_vld  <= 1'b0;
      raddr   <= '0;
      acc     <= '0;
      cnt     <= '0;
      k       <= '0;
    end else begin
      if (rd_en) begin
        raddr  <= raddr + ST_AW'(1);
        rd_vld <= 1'b1;
      end else if (absorb) begin
        rd_vld <= 1'b0;
      end
      // append a byte above the held bits, or pop one channel off the bottom
      if (absorb) begin
        acc <= acc | (ACC_W'(rdata) << cnt);
        cnt <= cnt + CNT_W'(BYTE_W);
      end else if (emit && chan_phase) begin
        acc <= acc >> CH_W;
        cnt <= cnt - CNT_W'(CH_W);
      end
      if (emit) begin
        k <= k + IDX_W'(1);
        if (k == ITEM_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_index  <= k;
      out_raw    <= raw_sel;
      out_mapped <= map_value(k, raw_sel, stick_center, knob_offset, fs || lost);
      out_fs     <= fs;
      out_lost   <= lost;
      out_last   <= (k == ITEM_LAST);
    end
  end

  assign res.valid        = out_valid;
  assign res.item_index   = out_index;
  assign res.raw_value    = out_raw;
  assign res.mapped_value = out_mapped;
  assign res.failsafe     = out_fs;
  assign res.frame_lost   = out_lost;
  assign res.last_item    = out_last;

  `SBFD_ASSERT_IMP(a_bank_split, clk, rst, busy, dbank != wbank)
  `SBFD_ASSERT_IMP(a_acc_bound, clk, rst, busy, cnt <= CNT_W'(ACC_W))
  `SBFD_ASSERT_IMP(a_flags_phase, clk, rst, emit && !chan_phase, raddr == CH_BYTES && cnt == '0 && !rd_vld)
  `SBFD_ASSERT_NXT(a_burst_end, clk, rst, emit && k == ITEM_LAST, !busy && res.valid && res.last_item)

endmodule

`default_nettype wire
